// File: hdl/dvuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Distinct value union filter package
// Item types shared by the search engine, the top level and the testbench.
// ============================================================================
package dvuf_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      restart;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_value;
        logic                      overflow;
    } out_item_t;

endpackage : dvuf_pkg
`default_nettype wire

// File: hdl/distinct_value_union_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Distinct value union filter
// Passes on each signed 32-bit value the first time it is seen since the last restart, drops repeats.
// ============================================================================
// Items enter through a two-entry input queue and results leave through a
// two-entry output queue, so either side may stall without holding up the
// other. The search engine takes one item at a time and sweeps the stored set
// through the single read port of its memory, one cell per cycle. A new value
// is compared against every value held (at most SET_DEPTH) before it is
// emitted; a repeat ends the sweep at the matching cell and is dropped.
// A restart item empties the set before its own value is handled. When the
// set is full, new values are passed on with the overflow flag set and are
// not stored. No clearing pass is needed after reset.
// ============================================================================
module distinct_value_union_filter_top
    import dvuf_pkg::*;
#(
    parameter int unsigned SET_DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    localparam int unsigned IN_W  = $bits(in_item_t);
    localparam int unsigned OUT_W = $bits(out_item_t);

    logic            q_in_empty;
    logic            q_in_pop;
    logic [IN_W-1:0] q_in_data;
    logic            q_out_full;
    logic            q_out_push;
    out_item_t       q_out_item;
    logic [OUT_W-1:0] q_out_data;

    dvuf_fifo #(
        .WIDTH (IN_W),
        .DEPTH (2)
    ) u_in_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .pop   (q_in_pop),
        .rdata (q_in_data),
        .empty (q_in_empty)
    );

    dvuf_search #(
        .SET_DEPTH (SET_DEPTH)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (q_in_empty),
        .in_pop   (q_in_pop),
        .in_item  (in_item_t'(q_in_data)),
        .out_full (q_out_full),
        .out_push (q_out_push),
        .out_item (q_out_item)
    );

    dvuf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_out_push),
        .wdata (q_out_item),
        .full  (q_out_full),
        .pop   (pop),
        .rdata (q_out_data),
        .empty (empty)
    );

    assign result = out_item_t'(q_out_data);

endmodule : distinct_value_union_filter_top
`default_nettype wire

// File: hdl/dvuf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Small synchronous queue
// Register-based first-in first-out buffer with push/full and pop/empty.
// ============================================================================
module dvuf_fifo #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      rd_ptr_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                     (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg[PW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg[PW-1:0]] <= wdata;
        end
    end

endmodule : dvuf_fifo
`default_nettype wire

// File: hdl/dvuf_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Distinct value search engine
// Sweeps the stored set for each item, appends new values while there is room and emits them.
// ============================================================================
module dvuf_search
    import dvuf_pkg::*;
#(
    parameter int unsigned SET_DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_empty,
    output logic          in_pop,
    input  wire in_item_t in_item,
    input  wire logic     out_full,
    output logic          out_push,
    output out_item_t     out_item
);

    localparam int unsigned AW = $clog2(SET_DEPTH);
    localparam int unsigned CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic                      rd_pend_reg;
    logic signed [VALUE_W-1:0] val_reg;

    logic [VALUE_W-1:0]        mem [SET_DEPTH];
    logic [VALUE_W-1:0]        rd_data_reg;

    logic                      match;
    logic                      swept;
    logic                      rd_en;
    logic                      store_full;
    logic                      wr_en;

    assign match      = rd_pend_reg && (rd_data_reg == val_reg);
    assign swept      = (idx_reg >= count_reg);
    assign rd_en      = (state_reg == ST_SCAN) && !match && !swept;
    assign store_full = (count_reg == CW'(SET_DEPTH));

    assign in_pop             = (state_reg == ST_IDLE) && !in_empty;
    assign out_push           = (state_reg == ST_EMIT) && !out_full;
    assign out_item.new_value = val_reg;
    assign out_item.overflow  = store_full;
    assign wr_en              = out_push && !store_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            val_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_pop)
                    begin
                        // A restart empties the set before its own value is looked up.
                        if (in_item.restart)
                        begin
                            count_reg <= '0;
                        end
                        val_reg     <= in_item.value;
                        idx_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (match)
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else if (!swept)
                    begin
                        idx_reg     <= idx_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_push)
                    begin
                        if (!store_full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Single-port set store: reads happen only while sweeping, writes only on emit.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

endmodule : dvuf_search
`default_nettype wire

// File: verif/tb_distinct_value_union_filter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Distinct value union filter testbench
// Streams signed values through the filter and checks that each value comes
// out once, on its first appearance, with the overflow flag set when the held
// set is full. A behavioural copy of the set predicts every result. Directed
// tests cover extreme values, restarts and a full set. Random value arrays
// then run under several patterns of sender idling and receiver stalling.
// ============================================================================
module tb_distinct_value_union_filter_top;
    import dvuf_pkg::*;

    localparam int unsigned SET_DEPTH   = 64;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned DRAIN_WAIT  = 300;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    // Behavioural copy of the held set and the results still to arrive.
    logic signed [VALUE_W-1:0] held_values [SET_DEPTH];
    int unsigned               held_count;
    out_item_t                 pending_members [$];

    int unsigned send_idle_pct;
    int unsigned pop_stall_pct;
    int unsigned fail_count;
    int unsigned cycle_count;

    distinct_value_union_filter_top #(
        .SET_DEPTH(SET_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .empty (empty),
        .pop   (pop),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic in_item_t make_item(input logic signed [VALUE_W-1:0] v,
                                           input logic r);
        in_item_t it;
        it.value   = v;
        it.restart = r;
        return it;
    endfunction

    // Works out whether an accepted item adds a member to the union.
    task automatic predict_union_member(input in_item_t it);
        out_item_t member;
        bit        seen;
        seen = 1'b0;
        if (it.restart)
            held_count = 0;
        for (int unsigned k = 0; k < held_count; k++)
        begin
            if (held_values[k] == it.value)
                seen = 1'b1;
        end
        if (!seen)
        begin
            member.new_value = it.value;
            if (held_count < SET_DEPTH)
            begin
                held_values[held_count] = it.value;
                held_count++;
                member.overflow = 1'b0;
            end
            else
            begin
                member.overflow = 1'b1;
            end
            pending_members.push_back(member);
        end
    endtask

    // Offers one item and returns at the edge where it is taken. Push is left
    // high so that a following item can go out on the very next cycle.
    task automatic push_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_union_member(it);
    endtask

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    // Result side: check what was taken at this edge, then choose the next pop.
    initial
    begin
        out_item_t want;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_members.size() == 0)
                begin
                    report_failure($sformatf("unexpected result: value %0d overflow %0b",
                                             result.new_value, result.overflow));
                end
                else
                begin
                    want = pending_members.pop_front();
                    if (result.new_value !== want.new_value)
                        report_failure($sformatf("new_value: expected %0d, got %0d",
                                                 want.new_value, result.new_value));
                    if (result.overflow !== want.overflow)
                        report_failure($sformatf("overflow for %0d: expected %0b, got %0b",
                                                 want.new_value, want.overflow,
                                                 result.overflow));
                end
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic test_extreme_values();
        push_item(make_item(32'sh8000_0000, 1'b1));
        push_item(make_item(32'sh7fff_ffff, 1'b0));
        push_item(make_item(32'sh0000_0000, 1'b0));
        push_item(make_item(-32'sd1, 1'b0));
        push_item(make_item(32'sd1, 1'b0));
        push_item(make_item(32'sh8000_0000, 1'b0));
        push_item(make_item(32'sh7fff_ffff, 1'b0));
        push_item(make_item(32'shaaaa_aaaa, 1'b0));
        push_item(make_item(32'sh5555_5555, 1'b0));
        push_item(make_item(-32'sd1, 1'b0));
        push_item(make_item(32'sh0000_0000, 1'b0));
        push_item(make_item(32'sh8000_0001, 1'b0));
    endtask

    // A restart empties the set, so its own value always comes out again.
    task automatic test_restart();
        push_item(make_item(-32'sd1, 1'b1));
        push_item(make_item(-32'sd1, 1'b0));
        push_item(make_item(-32'sd1, 1'b1));
        push_item(make_item(32'sh1234_5678, 1'b1));
        push_item(make_item(32'sh1234_5678, 1'b1));
        push_item(make_item(32'sh1234_5678, 1'b0));
    endtask

    // Once the set is full, new values come out flagged and are not held, so
    // a repeat of one is flagged again while a held value is still dropped.
    task automatic test_store_full();
        logic signed [VALUE_W-1:0] spare;
        spare = 32'sh7654_3210;
        for (int unsigned k = 0; k < SET_DEPTH; k++)
            push_item(make_item(32'sh0101_0101 * k - 32'sd5, k == 0));
        push_item(make_item(spare, 1'b0));
        push_item(make_item(spare, 1'b0));
        push_item(make_item(32'sh0101_0101 * 3 - 32'sd5, 1'b0));
        push_item(make_item(32'sh8000_0000, 1'b0));
        push_item(make_item(spare, 1'b1));
        push_item(make_item(spare, 1'b0));
    endtask

    // Arrays, each usually opened by a restart and drawn from a small pool so
    // that repeats are common; now and then a long set fills the store.
    task automatic send_union_sets(input int unsigned n_items);
        logic signed [VALUE_W-1:0] pool [96];
        int unsigned               sent;
        int unsigned               pool_size;
        int unsigned               set_len;
        bit                        long_set;
        in_item_t                  it;
        sent = 0;
        while (sent < n_items)
        begin
            long_set  = ($urandom_range(7) == 0);
            pool_size = long_set ? $urandom_range(96, 70) : $urandom_range(40, 1);
            set_len   = long_set ? $urandom_range(160, 80) : $urandom_range(60, 2);
            for (int unsigned k = 0; k < pool_size; k++)
            begin
                if (k != 0 && $urandom_range(3) == 0)
                    pool[k] = pool[0] ^ (32'sd1 << $urandom_range(31));
                else
                    pool[k] = $urandom;
            end
            for (int unsigned k = 0; k < set_len && sent < n_items; k++)
            begin
                it.value   = pool[$urandom_range(pool_size - 1)];
                it.restart = (k == 0);
                case ($urandom_range(19))
                    0: it.restart = ~it.restart;
                    1: it.value = $urandom;
                    default: ;
                endcase
                push_item(it);
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_union_sets(350);
        send_idle_pct = 81;
        pop_stall_pct = 0;
        send_union_sets(350);
        send_idle_pct = 0;
        pop_stall_pct = 81;
        send_union_sets(350);
        send_idle_pct = 33;
        pop_stall_pct = 33;
        send_union_sets(350);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        held_count    = 0;
        fail_count    = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_values();
        test_restart();
        test_store_full();
        test_random_phases();
        push <= 1'b0;

        while (pending_members.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        fail_count += pending_members.size();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
